>>> src/ifrd_pkg.sv
// Shared types and constants for the ICMP flood rate detector.
`timescale 1ns / 1ps
`default_nettype none
package ifrd_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP         = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST  = 8'd8;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  localparam logic [15:0] ALERT_THRESHOLD_RESET = 16'd100;
  localparam logic [15:0] WINDOW_SECONDS_RESET  = 16'd5;

  // Configuration register indexes
  localparam logic REG_ALERT_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW_SECONDS  = 1'b1;

  // Classified packet as it travels from front to back
  typedef struct packed {
    logic        counted;
    logic        echo;
    logic [31:0] source;
    logic [31:0] arrival;
  } item_t;

  // One row of the source table
  typedef struct packed {
    logic [31:0] source;
    logic [15:0] count;
    logic [31:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MATCH,
    ST_CALC,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

>>> src/ifrd_queue.sv
// Two-entry queue that decouples packet classification from table update.
`timescale 1ns / 1ps
`default_nettype none
module ifrd_queue import ifrd_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  item_t push_item,
  output logic  full,
  input  wire   pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  // Flags and head beat
  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ifrd_front.sv
// Front end: accepts packet headers, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module ifrd_front import ifrd_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] ether_type,
  input  wire  [7:0]  ip_protocol,
  input  wire  [31:0] source_address,
  input  wire  [7:0]  icmp_type,
  input  wire  [31:0] time_seconds,
  input  wire         pop,
  output logic        head_valid,
  output item_t       head_item
);

  item_t cls_item;
  logic  full;

  // Classify the header: only IPv4 ICMP touches the table
  always_comb begin
    cls_item.counted = (ether_type == ETHERTYPE_IPV4) && (ip_protocol == PROTO_ICMP);
    cls_item.echo    = (icmp_type == ICMP_ECHO_REQUEST);
    cls_item.source  = source_address;
    cls_item.arrival = time_seconds;
  end

  assign in_stall = full;

  ifrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_item  (cls_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

endmodule
`default_nettype wire

>>> src/ifrd_back.sv
// Back end: scans the source table, updates counts and drives the result beat.
`timescale 1ns / 1ps
`default_nettype none
module ifrd_back import ifrd_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  wire  [15:0] alert_threshold,
  input  wire  [15:0] window_seconds,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        counted,
  output logic        new_source,
  output logic        evicted,
  output logic        alert,
  output logic [15:0] packet_count
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  entry_t entry_mem [TABLE_ENTRIES];

  back_state_t       state;
  back_state_t       state_next;
  item_t             item;
  logic [IDX_W-1:0]  addr;
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  rptr;
  entry_t            rd_entry;
  logic              hit;
  logic [IDX_W-1:0]  slot;
  logic              was_full;
  logic              over;
  logic [15:0]       inc_count;

  logic        table_full;
  logic        last_entry;
  logic        src_match;
  logic        out_load;
  logic        mem_we;
  entry_t      wr_entry;
  logic        res_new;
  logic        res_evicted;
  logic        res_alert;
  logic [15:0] res_count;
  logic [31:0] elapsed;

  // Entries fill from index zero and never free up, so valid rows form a prefix
  assign table_full = (fill == FILL_W'(TABLE_ENTRIES));
  assign last_entry = (FILL_W'(addr) == fill - FILL_W'(1));
  assign src_match  = (rd_entry.source == item.source);
  assign elapsed    = item.arrival - rd_entry.start;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_item.counted) begin
            state_next = ST_DONE;
          end else if (fill == '0) begin
            state_next = ST_CALC;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_MATCH;
      ST_MATCH: begin
        if (src_match || last_entry) begin
          state_next = ST_CALC;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_CALC:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer and the result of the update
  always_comb begin
    q_pop       = (state == ST_IDLE) && q_valid;
    out_load    = (state == ST_DONE) && (!out_valid || !out_stall);
    mem_we      = out_load && item.counted;
    res_new     = 1'b0;
    res_evicted = 1'b0;
    res_alert   = 1'b0;
    res_count   = 16'd0;
    wr_entry.source = item.source;
    wr_entry.count  = 16'd1;
    wr_entry.start  = item.arrival;
    if (item.counted) begin
      if (!hit) begin
        res_new     = 1'b1;
        res_evicted = was_full;
        res_count   = 16'd1;
      end else if (over) begin
        res_count   = 16'd1;
      end else begin
        res_count   = inc_count;
        res_alert   = item.echo && (inc_count >= alert_threshold);
        wr_entry.count = res_alert ? 16'd0 : inc_count;
        wr_entry.start = res_alert ? item.arrival : rd_entry.start;
      end
    end
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[slot] <= wr_entry;
    end
    rd_entry <= entry_mem[addr];
  end

  // Work registers of the current packet
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item <= q_item;
        addr <= '0;
        hit  <= 1'b0;
      end
      ST_MATCH: begin
        if (src_match) begin
          hit  <= 1'b1;
          slot <= addr;
        end else if (!last_entry) begin
          addr <= addr + IDX_W'(1);
        end
      end
      ST_CALC: begin
        if (!hit) begin
          slot <= table_full ? rptr : fill[IDX_W-1:0];
        end
        was_full  <= table_full;
        over      <= (elapsed > {16'd0, window_seconds});
        inc_count <= (rd_entry.count == COUNT_MAX) ? COUNT_MAX
                                                   : rd_entry.count + 16'd1;
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  // Control state: sequencer, fill count, replacement pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      rptr  <= '0;
    end else begin
      state <= state_next;
      if (mem_we && !hit) begin
        if (was_full) begin
          rptr <= (rptr == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : rptr + IDX_W'(1);
        end else begin
          fill <= fill + FILL_W'(1);
        end
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      counted      <= item.counted;
      new_source   <= res_new;
      evicted      <= res_evicted;
      alert        <= res_alert;
      packet_count <= res_count;
    end
  end

endmodule
`default_nettype wire

>>> src/icmp_flood_rate_detector.sv
// Top level of the ICMP echo flood detector with per-source rate windows.
//
//   Channel   Direction  Beat
//   in        input      ether_type, ip_protocol, source_address, icmp_type, time_seconds
//   out       output     counted, new_source, evicted, alert, packet_count
//   cfg       input      cfg_write, cfg_index, cfg_data (no read-back)
//
// In the back end, a packet that is not IPv4 ICMP goes from idle straight to done.
// An ICMP packet passes a read and a match state for each table row scanned up to
// a match or the end of the filled rows (at most TABLE_ENTRIES), then calc and
// done; the table is searched one row at a time via one registered memory read port.
// Reset is synchronous; no clearing pass, a fill count marks the used rows.
// A two-beat queue lets the input keep accepting while a result is stalled.
`timescale 1ns / 1ps
`default_nettype none
module icmp_flood_rate_detector import ifrd_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] ether_type,
  input  wire  [7:0]  ip_protocol,
  input  wire  [31:0] source_address,
  input  wire  [7:0]  icmp_type,
  input  wire  [31:0] time_seconds,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        counted,
  output logic        new_source,
  output logic        evicted,
  output logic        alert,
  output logic [15:0] packet_count,
  input  wire         cfg_write,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data
);

  logic [15:0] alert_threshold;
  logic [15:0] window_seconds;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_threshold <= ALERT_THRESHOLD_RESET;
      window_seconds  <= WINDOW_SECONDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALERT_THRESHOLD: alert_threshold <= cfg_data;
        REG_WINDOW_SECONDS:  window_seconds  <= cfg_data;
        default:             alert_threshold <= alert_threshold;
      endcase
    end
  end

  ifrd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .ether_type     (ether_type),
    .ip_protocol    (ip_protocol),
    .source_address (source_address),
    .icmp_type      (icmp_type),
    .time_seconds   (time_seconds),
    .pop            (q_pop),
    .head_valid     (q_valid),
    .head_item      (q_item)
  );

  ifrd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .alert_threshold (alert_threshold),
    .window_seconds  (window_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .counted         (counted),
    .new_source      (new_source),
    .evicted         (evicted),
    .alert           (alert),
    .packet_count    (packet_count)
  );

endmodule
`default_nettype wire
